// ===== rtl/core/delimited_token_splitter_unit_assert.svh =====
// assertion macros for the delimited token splitter
// expects clk_i and rst_ni in the scope where the macros are used
`ifndef DELIMITED_TOKEN_SPLITTER_UNIT_ASSERT_SVH
`define DELIMITED_TOKEN_SPLITTER_UNIT_ASSERT_SVH

// clocked assertion, disabled while reset is asserted
`define DTS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// clocked assertion that also holds during reset
`define DTS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== rtl/core/dts_pkg.sv =====
// types and constants for the delimited token splitter
// no dependencies
package dts_pkg;

  // result kinds
  typedef enum logic [1:0] {
    KIND_CHAR       = 2'd0,
    KIND_TOKEN_END  = 2'd1,
    KIND_STRING_END = 2'd2
  } kind_e;

  // split modes
  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_FUZZY  = 2'd1,
    MODE_QUOTED = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  // quote tracking in quoted mode
  typedef enum logic [2:0] {
    QS_NORMAL = 3'd0,
    QS_ESC    = 3'd1,
    QS_DQ     = 3'd2,
    QS_DQ_ESC = 3'd3,
    QS_SQ     = 3'd4
  } qstate_e;

  // configuration register indexes
  localparam logic CFG_SPLIT_MODE = 1'b0;
  localparam logic CFG_DELIMITER  = 1'b1;

  localparam logic [7:0] DELIM_RESET = 8'd44;

  // special characters
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // most results one input byte can cause
  localparam int unsigned MaxResults = 3;

endpackage

// ===== rtl/core/delimited_token_splitter_unit.sv =====
// delimited token splitter top level
// depends on dts_pkg and delimited_token_splitter_unit_assert.svh
//
// Usage: a string streams in on the s_axis channel one byte per transfer,
// tdata the byte and tlast set on its final byte. Results stream out on
// m_axis one per transfer: tuser is the kind (token char, token end,
// string end), tdata the character (zero unless a token char), tlast set
// on the last result caused by one input byte.
// Each accepted byte is decoded into a result buffer of up to three
// entries; its first result is offered on the next cycle. The buffer
// drains one result per cycle while the receiver is ready; a byte
// causing zero or one result allows a new byte every cycle unless the
// receiver stalls. The next byte is taken in the same cycle that the
// last buffered result is transferred. Bytes that cause no result
// (quote marks, unused mode) only update state. Configuration: cfg_we_i
// writes register cfg_idx_i (0 split mode, 1 delimiter) from cfg_wdata_i;
// the user must write only while the block is idle, which the block does
// not enforce. Reset clears the quote and token state, the result buffer,
// and sets normal mode with a comma delimiter. When the receiver stalls,
// the buffer holds and s_axis_tready_o drops until it can be refilled.
module delimited_token_splitter_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration write port
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_wdata_i,
  // input stream
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] data_byte
  input  logic       s_axis_tlast_i,   // last_byte
  // result stream
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] char_out
  output logic [1:0] m_axis_tuser_o,   // [1:0] kind
  output logic       m_axis_tlast_o    // run_last
);

  localparam int unsigned Depth = dts_pkg::MaxResults;

  // configuration registers
  dts_pkg::mode_e   mode_q;
  logic [7:0]       delim_q;

  // splitter state
  dts_pkg::qstate_e quote_q, quote_d;
  logic             tok_q, tok_d;
  logic             sep_q, sep_d;

  // result buffer
  dts_pkg::kind_e   buf_kind_q [Depth];
  logic [7:0]       buf_char_q [Depth];
  logic [1:0]       cnt_q, cnt_d;

  // decode outputs
  dts_pkg::kind_e   res_kind [Depth];
  logic [7:0]       res_char [Depth];
  logic [1:0]       res_n;

  logic             in_xfer;
  logic             out_xfer;
  logic [7:0]       c;
  logic             last;

  assign c    = s_axis_tdata_i;
  assign last = s_axis_tlast_i;

  // handshakes
  assign m_axis_tvalid_o = (cnt_q != 2'd0);
  assign out_xfer        = m_axis_tvalid_o && m_axis_tready_i;
  assign s_axis_tready_o = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && m_axis_tready_i);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  // head of the buffer drives the output
  assign m_axis_tuser_o = buf_kind_q[0];
  assign m_axis_tdata_o = buf_char_q[0];
  assign m_axis_tlast_o = (cnt_q == 2'd1);

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= dts_pkg::MODE_NORMAL;
      delim_q <= dts_pkg::DELIM_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dts_pkg::CFG_SPLIT_MODE: mode_q  <= dts_pkg::mode_e'(cfg_wdata_i[1:0]);
        dts_pkg::CFG_DELIMITER:  delim_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // per-byte decode into a short result list
  always_comb begin
    logic             esc;
    logic             is_sep;
    dts_pkg::qstate_e qs;
    res_n   = 2'd0;
    for (int i = 0; i < Depth; i++) begin
      res_kind[i] = dts_pkg::KIND_CHAR;
      res_char[i] = 8'd0;
    end
    quote_d = quote_q;
    tok_d   = tok_q;
    sep_d   = sep_q;
    esc     = 1'b0;
    is_sep  = (c == dts_pkg::CH_SPACE) || (c == delim_q);
    qs      = dts_pkg::QS_NORMAL;

    case (mode_q)
      dts_pkg::MODE_NORMAL: begin
        if (c == delim_q) begin
          res_kind[res_n] = dts_pkg::KIND_TOKEN_END;
          res_n           = res_n + 2'd1;
        end else begin
          res_kind[res_n] = dts_pkg::KIND_CHAR;
          res_char[res_n] = c;
          res_n           = res_n + 2'd1;
          if (last) begin
            res_kind[res_n] = dts_pkg::KIND_TOKEN_END;
            res_n           = res_n + 2'd1;
          end
        end
      end
      dts_pkg::MODE_FUZZY: begin
        if (is_sep) begin
          // only the first separator of a run ends the token
          if (!sep_q) begin
            res_kind[res_n] = dts_pkg::KIND_TOKEN_END;
            res_n           = res_n + 2'd1;
          end
          sep_d = 1'b1;
        end else begin
          sep_d           = 1'b0;
          res_kind[res_n] = dts_pkg::KIND_CHAR;
          res_char[res_n] = c;
          res_n           = res_n + 2'd1;
        end
        if (last) begin
          res_kind[res_n] = dts_pkg::KIND_TOKEN_END;
          res_n           = res_n + 2'd1;
        end
      end
      dts_pkg::MODE_QUOTED: begin
        // quote state transition, unknown codes act as unquoted
        case (quote_q)
          dts_pkg::QS_ESC: begin
            esc = 1'b1;
            qs  = dts_pkg::QS_NORMAL;
          end
          dts_pkg::QS_DQ: begin
            if (c == dts_pkg::CH_DQUOTE)      qs = dts_pkg::QS_NORMAL;
            else if (c == dts_pkg::CH_BSLASH) qs = dts_pkg::QS_DQ_ESC;
            else begin
              esc = 1'b1;
              qs  = dts_pkg::QS_DQ;
            end
          end
          dts_pkg::QS_DQ_ESC: begin
            esc = 1'b1;
            qs  = dts_pkg::QS_DQ;
          end
          dts_pkg::QS_SQ: begin
            if (c == dts_pkg::CH_SQUOTE) qs = dts_pkg::QS_NORMAL;
            else begin
              esc = 1'b1;
              qs  = dts_pkg::QS_SQ;
            end
          end
          default: begin
            if (c == dts_pkg::CH_DQUOTE)      qs = dts_pkg::QS_DQ;
            else if (c == dts_pkg::CH_BSLASH) qs = dts_pkg::QS_ESC;
            else if (c == dts_pkg::CH_SQUOTE) qs = dts_pkg::QS_SQ;
            else                              qs = dts_pkg::QS_NORMAL;
          end
        endcase
        quote_d = qs;

        // unescaped quote marks are dropped
        if (esc || !(c inside {dts_pkg::CH_DQUOTE, dts_pkg::CH_BSLASH,
                               dts_pkg::CH_SQUOTE})) begin
          if ((c == delim_q) && !esc) begin
            res_kind[res_n] = dts_pkg::KIND_TOKEN_END;
            res_n           = res_n + 2'd1;
            tok_d           = 1'b0;
          end else begin
            res_kind[res_n] = dts_pkg::KIND_CHAR;
            res_char[res_n] = c;
            res_n           = res_n + 2'd1;
            tok_d           = 1'b1;
          end
        end
        // final token only if it holds a character
        if (last && tok_d) begin
          res_kind[res_n] = dts_pkg::KIND_TOKEN_END;
          res_n           = res_n + 2'd1;
        end
      end
      default: ;
    endcase

    // string end and state return to reset
    if (last) begin
      res_kind[res_n] = dts_pkg::KIND_STRING_END;
      res_char[res_n] = 8'd0;
      res_n           = res_n + 2'd1;
      quote_d         = dts_pkg::QS_NORMAL;
      tok_d           = 1'b0;
      sep_d           = 1'b0;
    end
  end

  // buffer fill count
  always_comb begin
    cnt_d = cnt_q;
    if (in_xfer)       cnt_d = res_n;
    else if (out_xfer) cnt_d = cnt_q - 2'd1;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= 2'd0;
      quote_q <= dts_pkg::QS_NORMAL;
      tok_q   <= 1'b0;
      sep_q   <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (in_xfer) begin
        quote_q <= quote_d;
        tok_q   <= tok_d;
        sep_q   <= sep_d;
      end
    end
  end

  // result buffer: load on input transfer, shift toward the head on output transfer
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      for (int i = 0; i < Depth; i++) begin
        buf_kind_q[i] <= res_kind[i];
        buf_char_q[i] <= res_char[i];
      end
    end else if (out_xfer) begin
      for (int i = 0; i < Depth - 1; i++) begin
        buf_kind_q[i] <= buf_kind_q[i+1];
        buf_char_q[i] <= buf_char_q[i+1];
      end
    end
  end

  `include "delimited_token_splitter_unit_assert.svh"

  // the final buffered result of a last byte is the string end
  `DTS_ASSERT(a_last_ends_string, (in_xfer && last) |=> ((cnt_q != 2'd0) && (buf_kind_q[cnt_q - 2'd1] == dts_pkg::KIND_STRING_END)), "last byte without string end")

  // state is back at reset after a last byte
  `DTS_ASSERT(a_state_cleared, (in_xfer && last) |=> ((quote_q == dts_pkg::QS_NORMAL) && !tok_q && !sep_q), "state not cleared after last byte")

  // a string end is always the last result of its byte
  `DTS_ASSERT(a_string_end_is_last, (m_axis_tvalid_o && (m_axis_tuser_o == dts_pkg::KIND_STRING_END)) |-> m_axis_tlast_o, "string end not marked last")

endmodule

// ===== tb/delimited_token_splitter_unit_tb.sv =====
`timescale 1ns / 100ps
// testbench for delimited_token_splitter_unit: byte strings in, token results out
// depends on dts_pkg and the delimited_token_splitter_unit rtl
module delimited_token_splitter_unit_tb;
  import dts_pkg::*;

  localparam int ResultLatency = 8;
  localparam int TargetBytes   = 320;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_item_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] ch;
    logic       run_last;
  } token_result_t;

  logic       clk_i           = 1'b0;
  logic       rst_ni          = 1'b0;
  logic       cfg_we_i        = 1'b0;
  logic       cfg_idx_i       = 1'b0;
  logic [7:0] cfg_wdata_i     = 8'h00;
  logic       s_axis_tvalid_i = 1'b0;
  logic       s_axis_tready_o;
  logic [7:0] s_axis_tdata_i  = 8'h00;
  logic       s_axis_tlast_i  = 1'b0;
  logic       m_axis_tvalid_o;
  logic       m_axis_tready_i = 1'b0;
  logic [7:0] m_axis_tdata_o;
  logic [1:0] m_axis_tuser_o;
  logic       m_axis_tlast_o;

  // bytes waiting to be sent and results waiting to arrive
  byte_item_t    byte_q[$];
  token_result_t token_results_q[$];
  int            mismatches = 0;
  int            bytes_made = 0;

  // mirror of the splitter registers and state
  mode_e      cur_mode     = MODE_NORMAL;
  logic [7:0] cur_delim    = DELIM_RESET;
  qstate_e    q_state      = QS_NORMAL;
  logic       tok_nonempty = 1'b0;
  logic       sep_run      = 1'b0;

  // sender burst state and receiver stall pattern
  int         burst_left = 0;
  int         gap_left   = 0;
  logic [7:0] ready_pat  = 8'hFF;
  int         pat_left   = 0;

  delimited_token_splitter_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // split one input byte into its token results and advance the state
  function automatic void split_byte(logic [7:0] c, logic lst);
    token_result_t batch[$];
    logic          esc;
    logic          is_quote;
    qstate_e       nq;
    esc = 1'b0;
    case (cur_mode)
      MODE_NORMAL: begin
        if (c == cur_delim) begin
          batch.insert(batch.size(), '{KIND_TOKEN_END, 8'h00, 1'b0});
        end else begin
          batch.insert(batch.size(), '{KIND_CHAR, c, 1'b0});
          if (lst) batch.insert(batch.size(), '{KIND_TOKEN_END, 8'h00, 1'b0});
        end
      end
      MODE_FUZZY: begin
        if (c == CH_SPACE || c == cur_delim) begin
          // only the first separator of a run ends the token
          if (!sep_run) batch.insert(batch.size(), '{KIND_TOKEN_END, 8'h00, 1'b0});
          sep_run = 1'b1;
        end else begin
          sep_run = 1'b0;
          batch.insert(batch.size(), '{KIND_CHAR, c, 1'b0});
        end
        if (lst) batch.insert(batch.size(), '{KIND_TOKEN_END, 8'h00, 1'b0});
      end
      MODE_QUOTED: begin
        nq = q_state;
        case (q_state)
          QS_ESC: begin
            esc = 1'b1;
            nq  = QS_NORMAL;
          end
          QS_DQ: begin
            if (c == CH_DQUOTE) nq = QS_NORMAL;
            else if (c == CH_BSLASH) nq = QS_DQ_ESC;
            else esc = 1'b1;
          end
          QS_DQ_ESC: begin
            esc = 1'b1;
            nq  = QS_DQ;
          end
          QS_SQ: begin
            if (c == CH_SQUOTE) nq = QS_NORMAL;
            else esc = 1'b1;
          end
          default: begin
            if (c == CH_DQUOTE) nq = QS_DQ;
            else if (c == CH_BSLASH) nq = QS_ESC;
            else if (c == CH_SQUOTE) nq = QS_SQ;
          end
        endcase
        q_state  = nq;
        is_quote = (c == CH_DQUOTE) || (c == CH_BSLASH) || (c == CH_SQUOTE);
        // unescaped quote marks are dropped
        if (esc || !is_quote) begin
          if (c == cur_delim && !esc) begin
            batch.insert(batch.size(), '{KIND_TOKEN_END, 8'h00, 1'b0});
            tok_nonempty = 1'b0;
          end else begin
            batch.insert(batch.size(), '{KIND_CHAR, c, 1'b0});
            tok_nonempty = 1'b1;
          end
        end
        if (lst && tok_nonempty) batch.insert(batch.size(), '{KIND_TOKEN_END, 8'h00, 1'b0});
      end
      default: ;
    endcase
    // end of string clears all state
    if (lst) begin
      batch.insert(batch.size(), '{KIND_STRING_END, 8'h00, 1'b0});
      q_state      = QS_NORMAL;
      tok_nonempty = 1'b0;
      sep_run      = 1'b0;
    end
    if (batch.size() > 0) batch[batch.size()-1].run_last = 1'b1;
    foreach (batch[i]) token_results_q.insert(token_results_q.size(), batch[i]);
  endfunction

  // sender: bursts of transfers with random gaps
  always @(posedge clk_i or negedge rst_ni) begin : drive_bytes
    byte_item_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= 8'h00;
      s_axis_tlast_i  <= 1'b0;
    end else if (!s_axis_tvalid_i || s_axis_tready_o) begin
      if (gap_left > 0 || byte_q.size() == 0) begin
        if (gap_left > 0) gap_left--;
        s_axis_tvalid_i <= 1'b0;
      end else begin
        nxt = byte_q.pop_front();
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i  <= nxt.data;
        s_axis_tlast_i  <= nxt.last;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          burst_left = $urandom_range(1, 20);
        end
      end
    end
  end

  // receiver: rotating ready pattern, replaced by a new random pattern
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (pat_left == 0) begin
        case ($urandom_range(0, 3))
          0:       ready_pat = 8'hFF;
          1:       ready_pat = 8'h01;
          default: ready_pat = 8'($urandom) | 8'h01;
        endcase
        pat_left = $urandom_range(16, 64);
      end
      m_axis_tready_i <= ready_pat[0];
      ready_pat = {ready_pat[0], ready_pat[7:1]};
      pat_left--;
    end
  end

  // check result transfers, then predict from the byte transfer
  always @(posedge clk_i) begin : check_results
    token_result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (token_results_q.size() == 0) begin
          $display("%0t: expected no result, actual kind %0d char %h last %b", $time,
                   m_axis_tuser_o, m_axis_tdata_o, m_axis_tlast_o);
          mismatches++;
        end else begin
          want = token_results_q.pop_front();
          if (m_axis_tuser_o !== want.kind) begin
            $display("%0t: kind expected %0d actual %0d", $time, want.kind, m_axis_tuser_o);
            mismatches++;
          end
          if (m_axis_tdata_o !== want.ch) begin
            $display("%0t: char expected %h actual %h", $time, want.ch, m_axis_tdata_o);
            mismatches++;
          end
          if (m_axis_tlast_o !== want.run_last) begin
            $display("%0t: last expected %b actual %b", $time, want.run_last,
                     m_axis_tlast_o);
            mismatches++;
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_o) split_byte(s_axis_tdata_i, s_axis_tlast_i);
    end
  end

  task automatic write_reg(logic idx, logic [7:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    if (idx == CFG_SPLIT_MODE) cur_mode = mode_e'(val[1:0]);
    else cur_delim = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic push_byte(logic [7:0] c, logic lst);
    byte_q.insert(byte_q.size(), '{c, lst});
    bytes_made++;
  endtask

  // nothing queued, nothing in flight, nothing owed
  task automatic wait_idle();
    while (byte_q.size() != 0 || s_axis_tvalid_i || token_results_q.size() != 0)
      @(posedge clk_i);
    repeat (ResultLatency) @(posedge clk_i);
  endtask

  // character mix weighted toward separators and quote marks
  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 9))
      0, 1:    return cur_delim;
      2:       return CH_SPACE;
      3:       return CH_DQUOTE;
      4:       return CH_SQUOTE;
      5:       return CH_BSLASH;
      6, 7:    return 8'h61 + 8'($urandom_range(0, 25));
      default: return 8'($urandom);
    endcase
  endfunction

  // whole strings with random content, some noise, optionally left open
  task automatic push_strings(int n_bytes, bit leave_open);
    int pushed;
    int len;
    pushed = 0;
    while (pushed < n_bytes) begin
      if ($urandom_range(0, 5) == 0) begin
        push_byte(8'($urandom), $urandom_range(0, 7) == 0);
        pushed++;
      end else begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 8);
        for (int k = 0; k < len; k++) push_byte(pick_char(), k == len - 1);
        pushed += len;
      end
    end
    if (leave_open)
      repeat ($urandom_range(1, 4)) push_byte(pick_char(), 1'b0);
  endtask

  initial begin : stimulus
    int    phase;
    mode_e mode;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // normal mode at reset values: empty token, trailing delimiter, byte extremes
    push_byte("a", 1'b0);
    push_byte(",", 1'b0);
    push_byte(",", 1'b0);
    push_byte("b", 1'b0);
    push_byte(",", 1'b1);
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b1);
    wait_idle();

    // fuzzy: leading separator run, mixed run, trailing separator
    write_reg(CFG_SPLIT_MODE, {6'd0, MODE_FUZZY});
    write_reg(CFG_DELIMITER, ";");
    push_byte(" ", 1'b0);
    push_byte(";", 1'b0);
    push_byte("a", 1'b0);
    push_byte(" ", 1'b0);
    push_byte("b", 1'b0);
    push_byte(";", 1'b1);
    wait_idle();

    // quoted: leading empty token, escapes in and out of quotes, escaped last byte
    write_reg(CFG_SPLIT_MODE, {6'd0, MODE_QUOTED});
    write_reg(CFG_DELIMITER, ",");
    push_byte(",", 1'b0);
    push_byte(CH_DQUOTE, 1'b0);
    push_byte(",", 1'b0);
    push_byte(CH_BSLASH, 1'b0);
    push_byte(CH_DQUOTE, 1'b0);
    push_byte(CH_DQUOTE, 1'b0);
    push_byte(CH_SQUOTE, 1'b0);
    push_byte(CH_BSLASH, 1'b0);
    push_byte(CH_SQUOTE, 1'b0);
    push_byte(CH_BSLASH, 1'b0);
    push_byte(",", 1'b1);
    wait_idle();

    // unused mode: only the string end comes out
    write_reg(CFG_SPLIT_MODE, {6'd0, MODE_NONE});
    push_byte("q", 1'b0);
    push_byte("r", 1'b1);
    wait_idle();

    // random phases, strings may stay open across a mode change
    phase = 0;
    while (bytes_made < TargetBytes) begin
      mode = (phase % 7 == 6) ? MODE_NONE : mode_e'(phase % 3);
      write_reg(CFG_SPLIT_MODE, {6'($urandom), mode});
      case (phase % 5)
        0:       write_reg(CFG_DELIMITER, 8'h00);
        1:       write_reg(CFG_DELIMITER, 8'hFF);
        2:       write_reg(CFG_DELIMITER, CH_SPACE);
        3:       write_reg(CFG_DELIMITER, DELIM_RESET);
        default: write_reg(CFG_DELIMITER, 8'($urandom));
      endcase
      push_strings($urandom_range(20, 45), $urandom_range(0, 2) == 0);
      wait_idle();
      phase++;
    end

    if (mismatches == 0) begin
      $display("delimited_token_splitter_unit test passed");
    end else begin
      $display("delimited_token_splitter_unit test failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("delimited_token_splitter_unit test failed");
    $finish;
  end

endmodule

// ===== delimited_token_splitter_unit.f =====
+incdir+rtl/core
rtl/core/dts_pkg.sv
rtl/core/delimited_token_splitter_unit.sv
tb/delimited_token_splitter_unit_tb.sv
